>>> hdl/rrect_pkg.sv
// ----------------------------------------------------------------------------
// rrect_pkg
// Shared widths, codes and types of the rounded rectangle outline rasterizer.
// ----------------------------------------------------------------------------
package rrect_pkg;

   localparam int COORD_BITS_DEFAULT = 14;
   localparam int COORD_MAX_BITS     = 16;
   // internal coordinate width, wide enough for origin plus size at any COORD_BITS
   localparam int PIX_BITS           = COORD_MAX_BITS + 2;
   localparam int SIZE_BITS          = 13;
   localparam int RADIUS_BITS        = 12;
   localparam int SCREEN_BITS        = 13;
   localparam int ADDR_BITS          = 32;
   localparam int COLOR_BITS         = 32;
   localparam int OUT_COORD_BITS     = 15;
   localparam int MUL_BITS           = PIX_BITS + SCREEN_BITS + 1;

   localparam int CSR_INDEX_BITS     = 2;
   localparam int CSR_DATA_BITS      = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_STRIDE     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROWS       = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_BASE = 2'd2;

   localparam logic [SCREEN_BITS-1:0] STRIDE_RESET     = 13'd1024;
   localparam logic [SCREEN_BITS-1:0] ROWS_RESET       = 13'd768;
   localparam logic [ADDR_BITS-1:0]   FRAME_BASE_RESET = 32'd0;

   localparam logic OP_START   = 1'b0;
   localparam logic OP_ADVANCE = 1'b1;

   typedef struct packed {
      logic [PIX_BITS-1:0]   x;
      logic [PIX_BITS-1:0]   y;
      logic [COLOR_BITS-1:0] color;
      logic                  last;
   } pix_type;

   typedef struct packed {
      logic [SCREEN_BITS-1:0] stride;
      logic [SCREEN_BITS-1:0] rows;
      logic [ADDR_BITS-1:0]   frame_base;
   } csr_type;

endpackage

>>> hdl/rrect_req_if.sv
// ----------------------------------------------------------------------------
// rrect_req_if
// Command channel: start a shape or advance one pixel.
// ----------------------------------------------------------------------------
interface rrect_req_if #(
   parameter int COORD_BITS = rrect_pkg::COORD_BITS_DEFAULT
);
   logic                                valid;
   logic                                ready;
   logic                                opcode;
   logic signed [COORD_BITS-1:0]        origin_x;
   logic signed [COORD_BITS-1:0]        origin_y;
   logic [rrect_pkg::SIZE_BITS-1:0]     rect_width;
   logic [rrect_pkg::SIZE_BITS-1:0]     rect_height;
   logic [rrect_pkg::RADIUS_BITS-1:0]   corner_radius;
   logic [rrect_pkg::COLOR_BITS-1:0]    draw_color;

   modport source (
      output valid, opcode, origin_x, origin_y, rect_width, rect_height,
             corner_radius, draw_color,
      input  ready
   );

   modport sink (
      input  valid, opcode, origin_x, origin_y, rect_width, rect_height,
             corner_radius, draw_color,
      output ready
   );
endinterface

>>> hdl/rrect_rsp_if.sv
// ----------------------------------------------------------------------------
// rrect_rsp_if
// Pixel write channel: coordinates, frame address, color and flags.
// ----------------------------------------------------------------------------
interface rrect_rsp_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [rrect_pkg::OUT_COORD_BITS-1:0] pixel_x;
   logic signed [rrect_pkg::OUT_COORD_BITS-1:0] pixel_y;
   logic [rrect_pkg::ADDR_BITS-1:0]           pixel_address;
   logic [rrect_pkg::COLOR_BITS-1:0]          pixel_color;
   logic                                      on_screen;
   logic                                      last_pixel;

   modport source (
      output valid, pixel_x, pixel_y, pixel_address, pixel_color, on_screen,
             last_pixel,
      input  ready
   );

   modport sink (
      input  valid, pixel_x, pixel_y, pixel_address, pixel_color, on_screen,
             last_pixel,
      output ready
   );
endinterface

>>> hdl/rrect_engine.sv
// ----------------------------------------------------------------------------
// rrect_engine
// Outline walker: edge counters and midpoint-circle arc stepper, one pixel
// coordinate per advance beat accepted mid-shape, held in an output register.
// ----------------------------------------------------------------------------
module rrect_engine #(
   parameter int COORD_BITS = rrect_pkg::COORD_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   rrect_req_if.sink          req,
   output logic               pix_valid,
   input  logic               pix_ready,
   output rrect_pkg::pix_type pix
);

   localparam int PB = rrect_pkg::PIX_BITS;
   localparam int SB = rrect_pkg::SIZE_BITS;
   localparam int RB = rrect_pkg::RADIUS_BITS;

   typedef enum logic [2:0] {
      PH_IDLE, PH_TOP, PH_BOTTOM, PH_LEFT, PH_RIGHT, PH_ARC
   } phase_type;

   // control state
   phase_type          phase_ff, phase_in;
   logic [1:0]         corner_ff, corner_in;
   logic [SB-1:0]      count_ff, count_in;
   logic [SB-1:0]      i_ff, i_in, j_ff, j_in;
   logic signed [15:0] d_ff, d_in;
   logic signed [14:0] sx_ff, sx_in, sy_ff, sy_in;
   logic               mirror_ff, mirror_in;
   logic               pix_valid_ff, pix_valid_in;

   // shape, latched on start
   logic [SB-1:0]      len_w_ff, len_h_ff;
   logic               has_h_ff, has_a_ff;
   logic [RB-1:0]      r_ff;
   logic [PB-1:0]      x0_ff, x1_ff, y0_ff, y1_ff, xr_ff, yr_ff, xc1_ff, yc1_ff;
   logic [rrect_pkg::COLOR_BITS-1:0] color_ff;

   rrect_pkg::pix_type pix_ff, pix_in;

   logic               accept, is_start, emit, arc_load, edge_done;
   logic [PB-1:0]      ox, oy, w_ext, h_ext, r_ext;
   logic [SB-1:0]      two_r, edge_len;
   logic [SB:0]        len_w_st, len_h_st, cnt1;
   logic               has_w_st, has_h_st, has_a_st;
   phase_type          start_phase;
   logic [RB-1:0]      r_src;

   logic               dpos;
   logic [SB-1:0]      i1, j1, u, v;
   logic signed [14:0] sx1, sy1;
   logic signed [15:0] d1, d2;
   logic [PB-1:0]      cx, cy, ax, ay, cnt_ext;

   assign accept   = req.valid && req.ready;
   assign is_start = req.opcode == rrect_pkg::OP_START;
   assign emit     = accept && !is_start && (phase_ff != PH_IDLE);
   assign req.ready = !pix_valid_ff || pix_ready;

   // start decode
   assign ox    = {{(PB-COORD_BITS){req.origin_x[COORD_BITS-1]}}, req.origin_x};
   assign oy    = {{(PB-COORD_BITS){req.origin_y[COORD_BITS-1]}}, req.origin_y};
   assign w_ext = PB'(req.rect_width);
   assign h_ext = PB'(req.rect_height);
   assign r_ext = PB'(req.corner_radius);
   assign two_r = {req.corner_radius, 1'b0};
   assign len_w_st = {1'b0, req.rect_width} - {1'b0, two_r};
   assign len_h_st = {1'b0, req.rect_height} - {1'b0, two_r};
   assign has_w_st = req.rect_width > two_r;
   assign has_h_st = req.rect_height > two_r;
   assign has_a_st = req.corner_radius != '0;

   always_comb begin
      priority if (has_w_st) begin
         start_phase = PH_TOP;
      end else if (has_h_st) begin
         start_phase = PH_LEFT;
      end else if (has_a_st) begin
         start_phase = PH_ARC;
      end else begin
         start_phase = PH_IDLE;
      end
   end

   assign r_src = is_start ? req.corner_radius : r_ff;

   // midpoint step for the first pixel of a mirrored pair
   assign dpos = !d_ff[15];
   assign j1   = dpos ? j_ff - 13'd1 : j_ff;
   assign sy1  = dpos ? sy_ff + 15'sd2 : sy_ff;
   assign d1   = dpos ? d_ff + 16'(sy1) : d_ff;
   assign i1   = i_ff + 13'd1;
   assign sx1  = sx_ff + 15'sd2;
   assign d2   = d1 + 16'(sx1);

   // edge counting
   assign edge_len  = (phase_ff == PH_TOP || phase_ff == PH_BOTTOM) ? len_w_ff : len_h_ff;
   assign cnt1      = {1'b0, count_ff} + 14'd1;
   assign edge_done = cnt1 == {1'b0, edge_len};
   assign cnt_ext   = PB'(count_ff);

   // arc pixel
   assign u  = mirror_ff ? i_ff : j1;
   assign v  = mirror_ff ? j_ff : i1;
   assign cx = (corner_ff[0] ^ corner_ff[1]) ? xc1_ff : xr_ff;
   assign cy = corner_ff[1] ? yc1_ff : yr_ff;

   always_comb begin
      unique case (corner_ff)
         2'd0: begin
            ax = cx - PB'(u);
            ay = cy - PB'(v);
         end
         2'd1: begin
            ax = cx + PB'(v);
            ay = cy - PB'(u);
         end
         2'd2: begin
            ax = cx + PB'(v);
            ay = cy + PB'(u);
         end
         default: begin
            ax = cx - PB'(u);
            ay = cy + PB'(v);
         end
      endcase
   end

   // next state
   always_comb begin
      phase_in  = phase_ff;
      corner_in = corner_ff;
      count_in  = count_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      d_in      = d_ff;
      sx_in     = sx_ff;
      sy_in     = sy_ff;
      mirror_in = mirror_ff;
      arc_load  = 1'b0;
      pix_in    = pix_ff;

      if (accept && is_start) begin
         phase_in  = start_phase;
         count_in  = '0;
         corner_in = '0;
         mirror_in = 1'b0;
         arc_load  = start_phase == PH_ARC;
      end else if (emit) begin
         case (phase_ff)
            PH_TOP: begin
               pix_in.x = xr_ff + cnt_ext;
               pix_in.y = y0_ff;
               count_in = cnt1[SB-1:0];
               if (edge_done) begin
                  phase_in = PH_BOTTOM;
                  count_in = '0;
               end
            end
            PH_BOTTOM: begin
               pix_in.x = xr_ff + cnt_ext;
               pix_in.y = y1_ff;
               count_in = cnt1[SB-1:0];
               if (edge_done) begin
                  count_in = '0;
                  priority if (has_h_ff) begin
                     phase_in = PH_LEFT;
                  end else if (has_a_ff) begin
                     phase_in = PH_ARC;
                     arc_load = 1'b1;
                  end else begin
                     phase_in = PH_IDLE;
                  end
               end
            end
            PH_LEFT: begin
               pix_in.x = x0_ff;
               pix_in.y = yr_ff + cnt_ext;
               count_in = cnt1[SB-1:0];
               if (edge_done) begin
                  phase_in = PH_RIGHT;
                  count_in = '0;
               end
            end
            PH_RIGHT: begin
               pix_in.x = x1_ff;
               pix_in.y = yr_ff + cnt_ext;
               count_in = cnt1[SB-1:0];
               if (edge_done) begin
                  count_in = '0;
                  if (has_a_ff) begin
                     phase_in = PH_ARC;
                     arc_load = 1'b1;
                  end else begin
                     phase_in = PH_IDLE;
                  end
               end
            end
            PH_ARC: begin
               pix_in.x = ax;
               pix_in.y = ay;
               if (!mirror_ff) begin
                  i_in      = i1;
                  j_in      = j1;
                  d_in      = d2;
                  sx_in     = sx1;
                  sy_in     = sy1;
                  mirror_in = 1'b1;
               end else begin
                  mirror_in = 1'b0;
                  if (!(i_ff < j_ff)) begin
                     if (corner_ff == 2'd3) begin
                        phase_in  = PH_IDLE;
                        corner_in = '0;
                     end else begin
                        corner_in = corner_ff + 2'd1;
                        arc_load  = 1'b1;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
         pix_in.color = color_ff;
         pix_in.last  = phase_in == PH_IDLE;
      end

      if (arc_load) begin
         i_in      = '0;
         j_in      = SB'(r_src);
         d_in      = 16'sd1 - $signed(16'(r_src));
         sx_in     = 15'sd1;
         sy_in     = -$signed(15'(r_src));
         mirror_in = 1'b0;
      end
   end

   always_comb begin
      if (emit) begin
         pix_valid_in = 1'b1;
      end else if (pix_ready) begin
         pix_valid_in = 1'b0;
      end else begin
         pix_valid_in = pix_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         corner_ff    <= '0;
         count_ff     <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         d_ff         <= '0;
         sx_ff        <= '0;
         sy_ff        <= '0;
         mirror_ff    <= 1'b0;
         pix_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         corner_ff    <= corner_in;
         count_ff     <= count_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         d_ff         <= d_in;
         sx_ff        <= sx_in;
         sy_ff        <= sy_in;
         mirror_ff    <= mirror_in;
         pix_valid_ff <= pix_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff <= pix_in;
      if (accept && is_start) begin
         len_w_ff <= len_w_st[SB-1:0];
         len_h_ff <= len_h_st[SB-1:0];
         has_h_ff <= has_h_st;
         has_a_ff <= has_a_st;
         r_ff     <= req.corner_radius;
         color_ff <= req.draw_color;
         x0_ff    <= ox;
         y0_ff    <= oy;
         x1_ff    <= ox + w_ext - PB'(1);
         y1_ff    <= oy + h_ext - PB'(1);
         xr_ff    <= ox + r_ext;
         yr_ff    <= oy + r_ext;
         xc1_ff   <= ox + w_ext - r_ext - PB'(1);
         yc1_ff   <= oy + h_ext - r_ext - PB'(1);
      end
   end

   assign pix_valid = pix_valid_ff;
   assign pix       = pix_ff;

endmodule

>>> hdl/rrect_addr.sv
// ----------------------------------------------------------------------------
// rrect_addr
// Frame address and clipping: row multiply stage, then final add into the
// result register.
// ----------------------------------------------------------------------------
module rrect_addr (
   input  logic               clock,
   input  logic               reset,
   input  rrect_pkg::csr_type csr,
   input  logic               pix_valid,
   output logic               pix_ready,
   input  rrect_pkg::pix_type pix,
   rrect_rsp_if.source        rsp
);

   localparam int PB = rrect_pkg::PIX_BITS;
   localparam int AB = rrect_pkg::ADDR_BITS;
   localparam int OB = rrect_pkg::OUT_COORD_BITS;
   localparam int MB = rrect_pkg::MUL_BITS;

   logic                             s2_v_ff, s2_v_in;
   logic [PB-1:0]                    s2_x_ff, s2_y_ff;
   logic [AB-1:0]                    s2_xb_ff, s2_prod_ff, xb_in;
   logic                             s2_on_ff, s2_last_ff, on_in;
   logic [rrect_pkg::COLOR_BITS-1:0] s2_color_ff;

   logic                             s3_v_ff, s3_v_in;
   logic [OB-1:0]                    s3_x_ff, s3_y_ff;
   logic [AB-1:0]                    s3_addr_ff;
   logic                             s3_on_ff, s3_last_ff;
   logic [rrect_pkg::COLOR_BITS-1:0] s3_color_ff;

   logic                             s3_take;
   logic signed [MB-1:0]             prod_full;
   logic                             on_x, on_y;

   assign s3_take   = !s3_v_ff || rsp.ready;
   assign pix_ready = !s2_v_ff || s3_take;

   assign prod_full = $signed(pix.y) * $signed({1'b0, csr.stride});
   assign xb_in     = csr.frame_base + {{(AB-PB){pix.x[PB-1]}}, pix.x};
   assign on_x      = !pix.x[PB-1] && (pix.x[PB-2:0] < (PB-1)'(csr.stride));
   assign on_y      = !pix.y[PB-1] && (pix.y[PB-2:0] < (PB-1)'(csr.rows));
   assign on_in     = on_x && on_y;

   assign s2_v_in = pix_ready ? pix_valid : s2_v_ff;
   assign s3_v_in = s3_take ? s2_v_ff : s3_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         s2_v_ff <= s2_v_in;
         s3_v_ff <= s3_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_ready) begin
         s2_x_ff     <= pix.x;
         s2_y_ff     <= pix.y;
         s2_xb_ff    <= xb_in;
         s2_prod_ff  <= prod_full[AB-1:0];
         s2_on_ff    <= on_in;
         s2_last_ff  <= pix.last;
         s2_color_ff <= pix.color;
      end
      if (s3_take) begin
         s3_x_ff     <= s2_x_ff[OB-1:0];
         s3_y_ff     <= s2_y_ff[OB-1:0];
         s3_addr_ff  <= s2_xb_ff + s2_prod_ff;
         s3_on_ff    <= s2_on_ff;
         s3_last_ff  <= s2_last_ff;
         s3_color_ff <= s2_color_ff;
      end
   end

   assign rsp.valid         = s3_v_ff;
   assign rsp.pixel_x       = $signed(s3_x_ff);
   assign rsp.pixel_y       = $signed(s3_y_ff);
   assign rsp.pixel_address = s3_addr_ff;
   assign rsp.pixel_color   = s3_color_ff;
   assign rsp.on_screen     = s3_on_ff;
   assign rsp.last_pixel    = s3_last_ff;

endmodule

>>> hdl/rounded_rect_outline_rasterizer.sv
// ----------------------------------------------------------------------------
// rounded_rect_outline_rasterizer
// Rounded rectangle outline to frame buffer pixel writes.
// ----------------------------------------------------------------------------
// A start beat latches origin, size, corner radius and color and yields no
// pixel; each advance beat then yields one pixel write: top, bottom, left and
// right edges, then the four corner arcs, with last_pixel on the final one.
// Advance beats after the shape is done yield nothing. The block takes one
// beat per clock unless stalled; a pixel goes from its advance beat through
// the walker register, the row multiply stage and the address add into the
// result register, and the channels stall only when all three stages hold
// pixels that the sink has not taken. Configuration writes are taken on any
// cycle with csr_we high and must only be made while the block is idle.
// ----------------------------------------------------------------------------
module rounded_rect_outline_rasterizer #(
   parameter int COORD_BITS = rrect_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   rrect_req_if.sink                            req_chan,
   rrect_rsp_if.source                          rsp_chan,
   input  logic                                 csr_we,
   input  logic [rrect_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rrect_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   rrect_pkg::csr_type csr_ff, csr_in;
   rrect_pkg::pix_type pix;
   logic               pix_valid, pix_ready;

   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         case (csr_index)
            rrect_pkg::CSR_STRIDE: begin
               csr_in.stride = csr_wdata[rrect_pkg::SCREEN_BITS-1:0];
            end
            rrect_pkg::CSR_ROWS: begin
               csr_in.rows = csr_wdata[rrect_pkg::SCREEN_BITS-1:0];
            end
            rrect_pkg::CSR_FRAME_BASE: begin
               csr_in.frame_base = csr_wdata[rrect_pkg::ADDR_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.stride     <= rrect_pkg::STRIDE_RESET;
         csr_ff.rows       <= rrect_pkg::ROWS_RESET;
         csr_ff.frame_base <= rrect_pkg::FRAME_BASE_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   rrect_engine #(
      .COORD_BITS (COORD_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .pix_valid (pix_valid),
      .pix_ready (pix_ready),
      .pix       (pix)
   );

   rrect_addr u_addr (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .pix_valid (pix_valid),
      .pix_ready (pix_ready),
      .pix       (pix),
      .rsp       (rsp_chan)
   );

endmodule

>>> verif/rrect_outline_checker.sv
// ----------------------------------------------------------------------------
// rrect_outline_checker
// Predicts and checks the pixel writes of the rounded rectangle rasterizer.
// ----------------------------------------------------------------------------
// Watches the command, pixel and register ports. A start beat loads a private
// outline walker (edges, then midpoint-circle corner arcs) and each accepted
// advance beat steps it; each pixel it yields is queued and compared field
// by field with the next accepted pixel beat.
// ----------------------------------------------------------------------------
module rrect_outline_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   rrect_req_if                                 req_tap,
   rrect_rsp_if                                 rsp_tap,
   input  logic                                 csr_we,
   input  logic [rrect_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rrect_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output int                                   pending,
   output int                                   mismatch_total,
   output int                                   pixel_total,
   output int                                   clipped_total,
   output int                                   outline_total
);

   localparam int OB = rrect_pkg::OUT_COORD_BITS;
   localparam int AB = rrect_pkg::ADDR_BITS;
   localparam int KB = rrect_pkg::COLOR_BITS;
   localparam int SB = rrect_pkg::SCREEN_BITS;

   typedef enum logic [2:0] {
      SEG_IDLE, SEG_TOP, SEG_BOTTOM, SEG_LEFT, SEG_RIGHT, SEG_ARC
   } segment_type;

   typedef enum int {CORNER_TL, CORNER_TR, CORNER_BR, CORNER_BL} corner_type;

   typedef struct {
      logic signed [OB-1:0] x;
      logic signed [OB-1:0] y;
      logic [AB-1:0]        address;
      logic [KB-1:0]        color;
      logic                 on_screen;
      logic                 last_pixel;
   } pixel_write_type;

   pixel_write_type expected_pixels[$];

   int            stride;
   int            rows;
   logic [AB-1:0] base_addr;

   segment_type   seg;
   corner_type    corner;
   int            edge_k;
   int            arc_i, arc_j, decision, x_term, y_term;
   bit            mirror;
   int            org_x, org_y, wid, hgt, rad;
   logic [KB-1:0] shape_color;

   function void arc_restart();
      arc_i    = 0;
      arc_j    = rad;
      decision = 1 - rad;
      x_term   = 1;
      y_term   = -rad;
      mirror   = 1'b0;
   endfunction

   // skip empty segments so the walker points at a pixel or is idle
   function void settle_walker();
      int side;
      while (1'b1) begin
         if (seg >= SEG_TOP && seg <= SEG_RIGHT) begin
            side = (seg <= SEG_BOTTOM) ? wid : hgt;
            if (edge_k < side - 2 * rad)
               return;
            edge_k = 0;
            seg = segment_type'(seg + 1);
            if (seg == SEG_ARC) begin
               corner = CORNER_TL;
               arc_restart();
            end
         end else if (seg == SEG_ARC) begin
            if (mirror || arc_i < arc_j)
               return;
            if (corner == CORNER_BL) begin
               seg = SEG_IDLE;
               corner = CORNER_TL;
               return;
            end
            corner = corner_type'(corner + 1);
            arc_restart();
         end else begin
            seg = SEG_IDLE;
            return;
         end
      end
   endfunction

   function void step_walker(output int px, output int py);
      int cx, cy;
      bit second;
      case (seg)
         SEG_TOP: begin
            px = org_x + rad + edge_k;
            py = org_y;
         end
         SEG_BOTTOM: begin
            px = org_x + rad + edge_k;
            py = org_y + hgt - 1;
         end
         SEG_LEFT: begin
            px = org_x;
            py = org_y + rad + edge_k;
         end
         SEG_RIGHT: begin
            px = org_x + wid - 1;
            py = org_y + rad + edge_k;
         end
         default: begin
            cx = (corner == CORNER_TR || corner == CORNER_BR) ? org_x + wid - rad - 1
                                                              : org_x + rad;
            cy = (corner >= CORNER_BR) ? org_y + hgt - rad - 1 : org_y + rad;
            second = mirror;
            if (!second) begin
               if (decision >= 0) begin
                  arc_j--;
                  y_term += 2;
                  decision += y_term;
               end
               arc_i++;
               x_term += 2;
               decision += x_term;
               mirror = 1'b1;
            end else begin
               mirror = 1'b0;
            end
            case (corner)
               CORNER_TL: begin
                  px = second ? cx - arc_i : cx - arc_j;
                  py = second ? cy - arc_j : cy - arc_i;
               end
               CORNER_TR: begin
                  px = second ? cx + arc_j : cx + arc_i;
                  py = second ? cy - arc_i : cy - arc_j;
               end
               CORNER_BR: begin
                  px = second ? cx + arc_j : cx + arc_i;
                  py = second ? cy + arc_i : cy + arc_j;
               end
               default: begin
                  px = second ? cx - arc_i : cx - arc_j;
                  py = second ? cy + arc_j : cy + arc_i;
               end
            endcase
         end
      endcase
      if (seg != SEG_ARC)
         edge_k++;
   endfunction

   function void take_command();
      pixel_write_type pw;
      int px, py;
      if (req_tap.opcode == rrect_pkg::OP_START) begin
         org_x       = int'(req_tap.origin_x);
         org_y       = int'(req_tap.origin_y);
         wid         = int'(req_tap.rect_width);
         hgt         = int'(req_tap.rect_height);
         rad         = int'(req_tap.corner_radius);
         shape_color = req_tap.draw_color;
         seg         = SEG_TOP;
         edge_k      = 0;
         corner      = CORNER_TL;
         mirror      = 1'b0;
         settle_walker();
         return;
      end
      if (seg == SEG_IDLE)
         return;
      step_walker(px, py);
      settle_walker();
      pw.x          = px[OB-1:0];
      pw.y          = py[OB-1:0];
      pw.address    = base_addr + 32'(px) + 32'(py) * 32'(stride);
      pw.color      = shape_color;
      pw.on_screen  = px >= 0 && py >= 0 && px < stride && py < rows;
      pw.last_pixel = seg == SEG_IDLE;
      expected_pixels.push_back(pw);
   endfunction

   function void match_field(input string field, input logic [31:0] want, got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         mismatch_total++;
      end
   endfunction

   function void check_pixel();
      pixel_write_type pw;
      if (expected_pixels.size() == 0) begin
         $error("pixel beat (%0d,%0d) with nothing expected",
                rsp_tap.pixel_x, rsp_tap.pixel_y);
         mismatch_total++;
         return;
      end
      pw = expected_pixels.pop_front();
      match_field("pixel_x", pw.x, rsp_tap.pixel_x);
      match_field("pixel_y", pw.y, rsp_tap.pixel_y);
      match_field("pixel_address", pw.address, rsp_tap.pixel_address);
      match_field("pixel_color", pw.color, rsp_tap.pixel_color);
      match_field("on_screen", pw.on_screen, rsp_tap.on_screen);
      match_field("last_pixel", pw.last_pixel, rsp_tap.last_pixel);
      pixel_total++;
      if (!pw.on_screen)
         clipped_total++;
      if (pw.last_pixel)
         outline_total++;
   endfunction

   initial begin
      mismatch_total = 0;
      pixel_total    = 0;
      clipped_total  = 0;
      outline_total  = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         stride      = int'(rrect_pkg::STRIDE_RESET);
         rows        = int'(rrect_pkg::ROWS_RESET);
         base_addr   = rrect_pkg::FRAME_BASE_RESET;
         seg         = SEG_IDLE;
         corner      = CORNER_TL;
         edge_k      = 0;
         arc_i       = 0;
         arc_j       = 0;
         decision    = 0;
         x_term      = 0;
         y_term      = 0;
         mirror      = 1'b0;
         org_x       = 0;
         org_y       = 0;
         wid         = 0;
         hgt         = 0;
         rad         = 0;
         shape_color = '0;
         expected_pixels.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               rrect_pkg::CSR_STRIDE:     stride = int'(csr_wdata[SB-1:0]);
               rrect_pkg::CSR_ROWS:       rows = int'(csr_wdata[SB-1:0]);
               rrect_pkg::CSR_FRAME_BASE: base_addr = csr_wdata;
               default: ;
            endcase
         end
         if (req_tap.valid === 1'b1 && req_tap.ready === 1'b1)
            take_command();
         if (rsp_tap.valid === 1'b1 && rsp_tap.ready === 1'b1)
            check_pixel();
      end
      pending <= expected_pixels.size();
   end

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the rounded rectangle outline rasterizer.
// ----------------------------------------------------------------------------
// Directed outlines at the field extremes, then random shapes (mostly small,
// complete outlines, some huge ones cut short by a restart) under several
// screen and frame base settings. Commands go out in random bursts, the pixel
// sink stalls on its own pattern; rrect_outline_checker does the checking.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CB = rrect_pkg::COORD_BITS_DEFAULT;
   localparam int ZB = rrect_pkg::SIZE_BITS;
   localparam int RB = rrect_pkg::RADIUS_BITS;
   localparam int KB = rrect_pkg::COLOR_BITS;

   typedef struct {
      logic          opcode;
      logic [CB-1:0] ox;
      logic [CB-1:0] oy;
      logic [ZB-1:0] w;
      logic [ZB-1:0] h;
      logic [RB-1:0] r;
      logic [KB-1:0] color;
   } shape_cmd_type;

   logic                                 clock = 1'b0;
   logic                                 reset;
   logic                                 csr_we;
   logic [rrect_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [rrect_pkg::CSR_DATA_BITS-1:0]  csr_wdata;
   logic [15:0]                          stall_tick = '0;

   int outstanding, mismatches, pixels, clipped, outlines;
   int beats_sent = 0;
   int burst_left = 0;

   rrect_req_if #(.COORD_BITS(CB)) req_bus ();
   rrect_rsp_if                    rsp_bus ();

   rounded_rect_outline_rasterizer #(.COORD_BITS(CB)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rrect_outline_checker chk (
      .clock          (clock),
      .reset          (reset),
      .req_tap        (req_bus),
      .rsp_tap        (rsp_bus),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .pending        (outstanding),
      .mismatch_total (mismatches),
      .pixel_total    (pixels),
      .clipped_total  (clipped),
      .outline_total  (outlines)
   );

   always #6 clock = ~clock;

   // sink: always ready, random, periodic gaps, coin flip; in turn by stall_tick[10:9]
   always @(posedge clock) begin
      stall_tick <= stall_tick + 16'd1;
      case (stall_tick[10:9])
         2'd0: rsp_bus.ready <= 1'b1;
         2'd1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
         2'd2: rsp_bus.ready <= (stall_tick[3:0] < 4'd11);
         default: rsp_bus.ready <= ($urandom_range(0, 1) == 1);
      endcase
   end

   function automatic shape_cmd_type start_cmd(input int ox, oy, w, h, r,
                                               input logic [31:0] color);
      shape_cmd_type c;
      c.opcode = rrect_pkg::OP_START;
      c.ox     = CB'(ox);
      c.oy     = CB'(oy);
      c.w      = ZB'(w);
      c.h      = ZB'(h);
      c.r      = RB'(r);
      c.color  = color;
      return c;
   endfunction

   function automatic shape_cmd_type advance_cmd();
      shape_cmd_type c;
      c = start_cmd($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                    $urandom());
      c.opcode = rrect_pkg::OP_ADVANCE;
      return c;
   endfunction

   task automatic send_cmd(input shape_cmd_type c);
      if (burst_left == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_bus.valid         <= 1'b1;
      req_bus.opcode        <= c.opcode;
      req_bus.origin_x      <= c.ox;
      req_bus.origin_y      <= c.oy;
      req_bus.rect_width    <= c.w;
      req_bus.rect_height   <= c.h;
      req_bus.corner_radius <= c.r;
      req_bus.draw_color    <= c.color;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      beats_sent++;
   endtask

   // hold off until every predicted pixel has come back and the pipe is empty
   task automatic drain();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      repeat (2) @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic program_screen(input logic [31:0] sw, sh, base);
      csr_we    <= 1'b1;
      csr_index <= rrect_pkg::CSR_STRIDE;
      csr_wdata <= sw;
      @(posedge clock);
      csr_index <= rrect_pkg::CSR_ROWS;
      csr_wdata <= sh;
      @(posedge clock);
      csr_index <= rrect_pkg::CSR_FRAME_BASE;
      csr_wdata <= base;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_shapes(input int n_items);
      shape_cmd_type c;
      int first, pick, n, es, eh;
      first = beats_sent;
      while (beats_sent - first < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            c = start_cmd($urandom(), $urandom(), $urandom(), $urandom(),
                          $urandom(), $urandom());
            n = $urandom_range(1, 30);
         end else begin
            c = start_cmd(int'($urandom_range(0, 100)) - 24,
                          int'($urandom_range(0, 80)) - 20,
                          $urandom_range(0, 28), $urandom_range(0, 28),
                          $urandom_range(0, 9), $urandom());
            es = int'(c.w) - 2 * int'(c.r);
            eh = int'(c.h) - 2 * int'(c.r);
            // arcs need about 5.7 r pixels; a few trailing advances land idle
            n = 2 * (es > 0 ? es : 0) + 2 * (eh > 0 ? eh : 0) + 6 * int'(c.r) + 4;
            if (pick < 14)
               n = $urandom_range(0, 6);
            else
               n += $urandom_range(0, 2);
         end
         // keep the item count of this phase on budget
         if (n > n_items - (beats_sent - first) - 1)
            n = n_items - (beats_sent - first) - 1;
         send_cmd(c);
         repeat (n) send_cmd(advance_cmd());
         if (pick >= 96)
            drain();
      end
   endtask

   initial begin
      reset                 = 1'b1;
      csr_we                = 1'b0;
      csr_index             = rrect_pkg::CSR_STRIDE;
      csr_wdata             = '0;
      req_bus.valid         = 1'b0;
      req_bus.opcode        = rrect_pkg::OP_START;
      req_bus.origin_x      = '0;
      req_bus.origin_y      = '0;
      req_bus.rect_width    = '0;
      req_bus.rect_height   = '0;
      req_bus.corner_radius = '0;
      req_bus.draw_color    = '0;
      rsp_bus.ready         = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed, reset screen settings
      send_cmd(advance_cmd());
      send_cmd(start_cmd(0, 0, 0, 0, 0, 32'h0000_0000));
      send_cmd(advance_cmd());
      send_cmd(start_cmd(-8192, -8192, 1, 1, 0, 32'h1234_5678));
      repeat (5) send_cmd(advance_cmd());
      send_cmd(start_cmd(8191, 8191, 8191, 8191, 0, 32'hFFFF_FFFF));
      repeat (3) send_cmd(advance_cmd());
      send_cmd(start_cmd(3, 2, 2, 2, 1, 32'h00FF_00FF));
      repeat (3) send_cmd(advance_cmd());
      send_cmd(start_cmd(100, 50, 8191, 8191, 4095, 32'h0F0F_0F0F));
      repeat (3) send_cmd(advance_cmd());
      send_cmd(start_cmd(20, 20, 3, 30, 5, 32'hA5A5_5A5A));
      repeat (2) send_cmd(advance_cmd());
      drain();

      program_screen(32'd4096, 32'd4096, 32'hFFFF_F000);
      random_shapes(180);
      drain();
      program_screen(32'd1, 32'd1, 32'h0000_0000);
      random_shapes(140);
      drain();
      program_screen(32'd0, 32'd0, 32'h0000_1234);
      random_shapes(100);
      drain();
      program_screen(32'h0000_1FFF, 32'h0000_1FFF, 32'hFFFF_FFFF);
      random_shapes(140);
      drain();
      // stride 64, 48 rows; upper write bits must be dropped
      program_screen(32'hDEAD_0040, 32'h0001_2030, $urandom());
      random_shapes(200);
      drain();
      program_screen(32'd1024, 32'd768, $urandom());
      random_shapes(170);
      drain();

      @(negedge clock);
      $display("summary: %0d command beats, %0d pixel writes checked, %0d clipped, %0d outlines",
               beats_sent, pixels, clipped, outlines);
      $display("summary: screens default, 4096x4096, 1x1, 0x0, 8191x8191, 64x48, 1024x768");
      if (mismatches == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

   initial begin
      #(12 * 400000);
      $display("testbench: done, errors");
      $finish;
   end

endmodule
